[rtl/core/itrd_pkg.sv]
// ----------------------------------------------------------------------------
// itrd_pkg: shared types and constants for integer_to_radix_digits
// Field widths, character codes, controller states and the command and status
// structs that tie the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package itrd_pkg;

  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 8;
  localparam int DIGIT_W       = 4;
  localparam int COUNT_W       = 5;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int SYMBOL_SLOTS  = 16;
  localparam int SYMS_PER_WORD = CFG_DATA_W / CHAR_W;
  localparam int DIGIT_SLOTS   = 32;
  localparam int SLOT_W        = $clog2(DIGIT_SLOTS);
  localparam int TOTAL_W       = SLOT_W + 1;
  localparam int BITS_PER_STEP = 8;
  localparam int STEPS_PER_DIG = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(STEPS_PER_DIG);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SYMBOL_COUNT = 2'd0,
    REG_SYMBOLS_LOW  = 2'd1,
    REG_SYMBOLS_HIGH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef logic [SYMBOL_SLOTS-1:0][CHAR_W-1:0] sym_table_t;

  typedef struct packed {
    logic load;
    logic divide;
    logic emit_sign;
    logic emit_digit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic negative;
    logic digit_done;
    logic quotient_zero;
    logic final_digit;
    logic slot_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/itrd_channels.sv]
// ----------------------------------------------------------------------------
// itrd channels: valid/ready interfaces of integer_to_radix_digits
// Input value channel, character output channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface itrd_value_if;
  logic                                valid;
  logic                                ready;
  logic signed [itrd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itrd_char_if;
  logic                         valid;
  logic                         ready;
  logic [itrd_pkg::CHAR_W-1:0]  character;
  logic                         last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface itrd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [itrd_pkg::CFG_INDEX_W-1:0] index;
  logic [itrd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/itrd_cfg.sv]
// ----------------------------------------------------------------------------
// itrd_cfg: register file and base check
// Holds the radix and the symbol bytes in use, and registers whether the
// configured symbol set forms a valid base.
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_cfg #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  itrd_cfg_if.sink                          cfg,
  output logic [itrd_pkg::COUNT_W-1:0]      radix,
  output itrd_pkg::sym_table_t              sym_tab,
  output logic                              base_ok
);
  import itrd_pkg::*;

  logic [MAX_SYMBOLS-1:0][CHAR_W-1:0] sym;
  logic                               wr_count;
  logic                               wr_low;
  logic                               wr_high;
  logic                               base_ok_next;

  function automatic logic bad_symbol(input logic [CHAR_W-1:0] s);
    return (s == '0) || (s == CHAR_PLUS) || (s == CHAR_MINUS) || (s == CHAR_SPACE) ||
           ((s >= CHAR_TAB) && (s <= CHAR_CR));
  endfunction

  assign cfg.ready = 1'b1;
  assign wr_count  = cfg.valid && (cfg.index == REG_SYMBOL_COUNT);
  assign wr_low    = cfg.valid && (cfg.index == REG_SYMBOLS_LOW);
  assign wr_high   = cfg.valid && (cfg.index == REG_SYMBOLS_HIGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= '0;
    end else if (wr_count) begin
      radix <= cfg.data[COUNT_W-1:0];
    end
  end

  // only the bytes that can ever be in use are stored
  for (genvar k = 0; k < SYMBOL_SLOTS; k++) begin : g_sym
    if (k < MAX_SYMBOLS) begin : g_used
      if (k < SYMS_PER_WORD) begin : g_low
        always_ff @(posedge clk) begin
          if (rst) begin
            sym[k] <= '0;
          end else if (wr_low) begin
            sym[k] <= cfg.data[CHAR_W*k +: CHAR_W];
          end
        end
      end else begin : g_high
        always_ff @(posedge clk) begin
          if (rst) begin
            sym[k] <= '0;
          end else if (wr_high) begin
            sym[k] <= cfg.data[CHAR_W*(k-SYMS_PER_WORD) +: CHAR_W];
          end
        end
      end
      assign sym_tab[k] = sym[k];
    end else begin : g_unused
      assign sym_tab[k] = '0;
    end
  end

  // pairwise compares, all independent
  always_comb begin
    base_ok_next = (radix >= COUNT_W'(2)) && (radix <= COUNT_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (COUNT_W'(i) < radix) begin
        if (bad_symbol(sym[i])) begin
          base_ok_next = 1'b0;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if ((COUNT_W'(j) < radix) && (sym[j] == sym[i])) begin
            base_ok_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_ok <= 1'b0;
    end else begin
      base_ok <= base_ok_next;
    end
  end

  // the flag is registered and so trails a radix write; check the unregistered value
  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    base_ok_next |-> (radix >= COUNT_W'(2)) && (radix <= COUNT_W'(MAX_SYMBOLS)))
    else $error("valid base flagged with radix out of range");

endmodule

`default_nettype wire

[rtl/core/itrd_ctrl.sv]
// ----------------------------------------------------------------------------
// itrd_ctrl: sequencing state machine
// Steps one value through base check, digit extraction, sign and digit output.
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  base_ok,
  input  itrd_pkg::dp_status_t  status,
  output itrd_pkg::ctrl_cmd_t   cmd
);
  import itrd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = base_ok ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        if (status.digit_done && status.quotient_zero) begin
          state_next = status.negative ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (status.slot_free) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.slot_free && status.final_digit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: ;
      ST_DIVIDE: cmd.divide = 1'b1;
      ST_SIGN:   cmd.emit_sign = status.slot_free;
      ST_EMIT:   cmd.emit_digit = status.slot_free;
      default: ;
    endcase
  end

  a_sign_only_negative: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN) |-> status.negative)
    else $error("sign state entered for a non-negative value");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> status.slot_free)
    else $error("character issued into an occupied output register");

endmodule

`default_nettype wire

[rtl/core/itrd_datapath.sv]
// ----------------------------------------------------------------------------
// itrd_datapath: magnitude divider, digit store and output register
// Restoring division by the radix, eight quotient bits per cycle; remainders
// are kept least significant first and read back in reverse.
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  itrd_pkg::ctrl_cmd_t                  cmd,
  output itrd_pkg::dp_status_t                 status,
  input  logic signed [itrd_pkg::VALUE_W-1:0]  in_value,
  input  logic [itrd_pkg::COUNT_W-1:0]         radix,
  input  itrd_pkg::sym_table_t                 sym_tab,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [itrd_pkg::CHAR_W-1:0]          out_char,
  output logic                                 out_last
);
  import itrd_pkg::*;

  logic                 negative;
  logic [VALUE_W-1:0]   mag;
  logic [VALUE_W-1:0]   mag_next;
  logic [VALUE_W-1:0]   value_u;
  logic [DIGIT_W-1:0]   rem;
  logic [DIGIT_W-1:0]   rem_next;
  logic [COUNT_W-1:0]   partial;
  logic [STEP_W-1:0]    step;
  logic [TOTAL_W-1:0]   cnt;
  logic [TOTAL_W-1:0]   cnt_m1;
  logic [DIGIT_W-1:0]   store [DIGIT_SLOTS];

  assign value_u = VALUE_W'(in_value);
  assign cnt_m1  = cnt - TOTAL_W'(1);

  // eight restoring steps; remainder always stays below the radix
  always_comb begin
    mag_next = mag;
    rem_next = rem;
    partial  = '0;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      partial  = {rem_next, mag_next[VALUE_W-1]};
      mag_next = {mag_next[VALUE_W-2:0], 1'b0};
      if (partial >= radix) begin
        rem_next    = DIGIT_W'(partial - radix);
        mag_next[0] = 1'b1;
      end else begin
        rem_next = DIGIT_W'(partial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      negative <= 1'b0;
      step     <= '0;
      cnt      <= '0;
    end else if (cmd.load) begin
      negative <= in_value[VALUE_W-1];
      step     <= '0;
      cnt      <= '0;
    end else if (cmd.divide) begin
      step <= step + STEP_W'(1);
      if (&step) cnt <= cnt + TOTAL_W'(1);
    end else if (cmd.emit_digit) begin
      cnt <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= in_value[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;
      rem <= '0;
    end else if (cmd.divide) begin
      mag <= mag_next;
      rem <= (&step) ? '0 : rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.divide && (&step)) begin
      store[cnt[SLOT_W-1:0]] <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= CHAR_MINUS;
      out_last <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= sym_tab[store[cnt_m1[SLOT_W-1:0]]];
      out_last <= (cnt == TOTAL_W'(1));
    end
  end

  assign status.negative      = negative;
  assign status.digit_done    = &step;
  assign status.quotient_zero = (mag_next == '0);
  assign status.final_digit   = (cnt == TOTAL_W'(1));
  assign status.slot_free     = !out_valid || out_ready;

  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.divide && (&step)) |-> !cnt[TOTAL_W-1])
    else $error("digit store overflow");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit |-> (cnt != '0))
    else $error("digit read from an empty store");

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_digit && (cnt == TOTAL_W'(1))) |=> (out_valid && out_last))
    else $error("final digit not flagged as last");

endmodule

`default_nettype wire

[rtl/core/integer_to_radix_digits.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_digits: signed 32-bit integer to text in a configured base
// Top level: register file, sequencing controller and conversion datapath.
// ----------------------------------------------------------------------------
//
// Each transaction on item carries one signed 32-bit value; the block answers
// with that value's text on the text channel, one character per transaction,
// most significant digit first, a leading '-' for negative values and last set
// on the final character. The most negative value is written with magnitude
// 2147483648, and zero is written as the digit-0 symbol. The radix is the
// symbol_count register (index 0); symbol bytes for digits 0-7 and 8-15 sit in
// registers 1 and 2, digit 0 / digit 8 in the low byte. If the base is
// invalid (fewer than two or more than MAX_SYMBOLS symbols, a symbol that is
// zero, '+', '-', space or 9..13, or a repeated symbol) the value produces no
// characters. Registers must be written over cfg only while the block is idle;
// the block itself does not enforce this. A write to index 3 is dropped. One
// value at a time: after acceptance the controller checks the base, then
// the divider extracts the digits (it resolves 8 quotient bits per cycle
// against the radix), then one character leaves per cycle while text is
// ready. The next value is taken as soon as the last character sits in the
// output register.
//
`default_nettype none

module integer_to_radix_digits #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic           clk,
  input  logic           rst,
  itrd_value_if.sink     item,
  itrd_char_if.source    text,
  itrd_cfg_if.sink       cfg
);
  import itrd_pkg::*;

  logic [COUNT_W-1:0] radix;
  sym_table_t         sym_tab;
  logic               base_ok;
  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic               in_ready;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  // Radix and symbol registers, base validity registered every cycle.
  itrd_cfg #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .radix   (radix),
    .sym_tab (sym_tab),
    .base_ok (base_ok)
  );

  // Sequencer: accept, check, divide, sign, emit.
  itrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .base_ok  (base_ok),
    .status   (status),
    .cmd      (cmd)
  );

  // Divider, digit store and output register.
  itrd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_value  (item.value),
    .radix     (radix),
    .sym_tab   (sym_tab),
    .out_ready (text.ready),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  assign item.ready     = in_ready;
  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last      = out_last;

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for integer_to_radix_digits
// Drives signed values and symbol tables and predicts every text character.
// Each character is compared, in order, against the predicted text. Runs a
// directed set of edge values and bad bases, then random phases, each with a
// fresh symbol table.
// ----------------------------------------------------------------------------
import itrd_pkg::*;

typedef struct packed {
  logic [CHAR_W-1:0] character;
  logic              last;
} text_char_t;

typedef logic signed [VALUE_W-1:0] value_list_t[$];

// Bytes a base may not use as a digit symbol.
function automatic bit symbol_allowed(input logic [CHAR_W-1:0] b);
  return !(b == 8'h00 || b == CHAR_PLUS || b == CHAR_MINUS || b == CHAR_SPACE ||
           (b >= CHAR_TAB && b <= CHAR_CR));
endfunction

class text_scoreboard;
  logic [COUNT_W-1:0] radix;
  sym_table_t         symbols;
  text_char_t         expected_text[$];
  int unsigned        errors;

  function new();
    radix   = '0;
    symbols = '0;
    errors  = 0;
  endfunction

  function void note_register(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SYMBOL_COUNT: radix = data[COUNT_W-1:0];
      REG_SYMBOLS_LOW:  symbols[SYMS_PER_WORD-1:0] = data;
      REG_SYMBOLS_HIGH: symbols[SYMBOL_SLOTS-1:SYMS_PER_WORD] = data;
      default: ;
    endcase
  endfunction

  function bit base_ok();
    if (radix < 2 || radix > SYMBOL_SLOTS) return 1'b0;
    for (int i = 0; i < radix; i++) begin
      if (!symbol_allowed(symbols[i])) return 1'b0;
      for (int j = i + 1; j < radix; j++)
        if (symbols[j] == symbols[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected text of one accepted value.
  function void note_value(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits[$];
    text_char_t         c;
    if (!base_ok()) return;
    mag = v;
    if (v[VALUE_W-1]) begin
      mag = ~mag + 1'b1;   // most negative value stays 0x80000000
      c.character = CHAR_MINUS;
      c.last      = 1'b0;
      expected_text.push_back(c);
    end
    do begin
      digits.push_back(DIGIT_W'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    for (int i = digits.size() - 1; i >= 0; i--) begin
      c.character = symbols[digits[i]];
      c.last      = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  function void check_char(input logic [CHAR_W-1:0] character, input logic last);
    text_char_t e;
    if (expected_text.size() == 0) begin
      $error("character: none expected, got 0x%02h last %0b", character, last);
      errors++;
      return;
    end
    e = expected_text.pop_front();
    if (character !== e.character) begin
      $error("character: expected 0x%02h, got 0x%02h", e.character, character);
      errors++;
    end
    if (last !== e.last) begin
      $error("last: expected %0b, got %0b", e.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_text.size();
  endfunction
endclass

module tb;
  // Index 3 maps to no register; the block must drop the write.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
  // Longest conversion is 32 binary digits; settle time after a phase, also
  // covers a bad-base value that leaves no characters behind.
  localparam int SETTLE_CYCLES  = 200;
  // Cycles with no transaction on any channel before the run is declared hung.
  localparam int HANG_LIMIT     = 4000;
  localparam int RANDOM_VALUES  = 270;

  logic clk;
  logic rst;
  bit   quiet;   // phase with no idling on either side

  itrd_value_if item_ch();
  itrd_char_if  text_ch();
  itrd_cfg_if   cfg_ch();

  integer_to_radix_digits dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .text (text_ch),
    .cfg  (cfg_ch)
  );

  text_scoreboard sb = new();
  int             idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitors: every transaction is sampled at the rising edge. Register writes
  // update the predictor's copy of the base; values push predicted text; each
  // character pops and checks the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.note_register(cfg_ch.index, cfg_ch.data);
      if (item_ch.valid && item_ch.ready)
        sb.note_value(item_ch.value);
      if (text_ch.valid && text_ch.ready)
        sb.check_char(text_ch.character, text_ch.last);
    end
  end

  // Hang detector: counts cycles in which nothing moves on any channel.
  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (item_ch.valid && item_ch.ready) ||
        (text_ch.valid && text_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Character sink: back-pressure in bursts, mostly short, a few long.
  initial begin : text_sink
    int stall_left;
    int r;
    stall_left    = 0;
    text_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        stall_left    = 0;
        text_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        text_ch.ready = 1'b0;
      end else begin
        text_ch.ready = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 20)      stall_left = $urandom_range(1, 3);
        else if (r < 24) stall_left = $urandom_range(10, 40);
      end
    end
  end

  // Gap before a value transaction; zero most of the time.
  function automatic int idle_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // 16 distinct legal symbols at random.
  function automatic sym_table_t random_base_symbols();
    sym_table_t   t;
    bit [255:0]   used;
    logic [CHAR_W-1:0] b;
    used = '0;
    for (int i = 0; i < SYMBOL_SLOTS; i++) begin
      do b = CHAR_W'($urandom_range(0, 255)); while (!symbol_allowed(b) || used[b]);
      used[b] = 1'b1;
      t[i]    = b;
    end
    return t;
  endfunction

  // Any of the bytes that make a base invalid.
  function automatic logic [CHAR_W-1:0] bad_symbol();
    int r;
    r = $urandom_range(0, 8);
    case (r)
      0:       return 8'h00;
      1:       return CHAR_PLUS;
      2:       return CHAR_MINUS;
      3:       return CHAR_SPACE;
      default: return CHAR_TAB + CHAR_W'(r - 4);
    endcase
  endfunction

  // Called just after a falling edge; returns at the falling edge after the
  // transaction, with valid still high so back-to-back values need no gap.
  task automatic send_value(input logic signed [VALUE_W-1:0] v, input int gap);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.value = v;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Block is idle here. Upper bits of the count word are noise the block must
  // drop; the unmapped index gets a random write every time.
  task automatic load_base(input logic [COUNT_W-1:0] count, input sym_table_t t);
    logic [CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    w[COUNT_W-1:0] = count;
    write_reg(REG_SYMBOL_COUNT, w);
    write_reg(REG_SYMBOLS_LOW,  t[SYMS_PER_WORD-1:0]);
    write_reg(REG_SYMBOLS_HIGH, t[SYMBOL_SLOTS-1:SYMS_PER_WORD]);
    write_reg(REG_UNMAPPED,     {$urandom, $urandom});
  endtask

  // Block is idle when we return: all text received, then a settle pause.
  task automatic settle();
    item_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One phase: new base, then the values. Midway (with four or more values) and
  // now and then the sender holds off until every predicted character has come back.
  task automatic run_phase(input logic [COUNT_W-1:0] count, input sym_table_t t,
                           input value_list_t vals);
    load_base(count, t);
    foreach (vals[k]) begin
      if ((vals.size() >= 4 && k == vals.size() / 2) || $urandom_range(0, 24) == 0) begin
        item_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      send_value(vals[k], idle_gap());
    end
    settle();
  endtask

  // Random value: full range, small magnitudes, the extremes, powers of two.
  function automatic logic signed [VALUE_W-1:0] random_value();
    logic signed [VALUE_W-1:0] v;
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6:          v = $urandom_range(0, 40);
      7: begin
        case ($urandom_range(0, 4))
          0:       v = VALUE_MIN;
          1:       v = VALUE_MAX;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
        return v;
      end
      default: begin
        k = $urandom_range(0, 31);
        v = (32'sd1 <<< k) - $urandom_range(0, 1);
      end
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    sym_table_t          t;
    sym_table_t          t_bad;
    value_list_t         vals;
    logic [CHAR_W-1:0]   bad_syms[6];
    logic [COUNT_W-1:0]  bad_counts[4];
    logic [COUNT_W-1:0]  count;
    int                  good_values;
    int                  n;
    int                  i;
    int                  j;

    bad_syms   = '{8'h00, CHAR_PLUS, CHAR_MINUS, CHAR_SPACE, CHAR_TAB, CHAR_CR};
    bad_counts = '{5'd0, 5'd1, 5'd17, 5'd31};
    quiet         = 1'b0;
    rst           = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.value = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_SYMBOL_COUNT;
    cfg_ch.data   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Out of reset the radix is zero: a value must yield no text.
    send_value(32'sd5, 0);
    settle();

    // Decimal, slots 10..15 random junk that must be ignored.
    t = random_base_symbols();
    for (i = 0; i < SYMBOL_SLOTS; i++)
      if (i < 10) t[i] = CHAR_W'(8'h30 + i);
      else if ($urandom_range(0, 1)) t[i] = CHAR_W'($urandom_range(0, 255));
    vals = '{32'sd0, 32'sd7, -32'sd7, VALUE_MAX, VALUE_MIN, -VALUE_MAX, 32'sd10, -32'sd1};
    run_phase(5'd10, t, vals);

    // Zero, '+', '-', space, tab and CR, each inside the used range, kill the base.
    foreach (bad_syms[k]) begin
      t_bad    = t;
      t_bad[3] = bad_syms[k];
      vals     = '{-32'sd12345};
      run_phase(5'd10, t_bad, vals);
    end

    // Repeated symbol.
    t_bad    = t;
    t_bad[9] = t_bad[2];
    vals     = '{32'sd99};
    run_phase(5'd10, t_bad, vals);

    // Radix too small and too large.
    foreach (bad_counts[k]) begin
      vals = '{32'sd5};
      run_phase(bad_counts[k], t, vals);
    end

    // Binary: longest text. Unused slots may hold anything, even bad bytes.
    for (i = 0; i < SYMBOL_SLOTS; i++) t[i] = CHAR_W'($urandom_range(0, 255));
    t[0] = 8'h30;
    t[1] = 8'h31;
    vals = '{VALUE_MIN, VALUE_MAX, 32'sd0, 32'sd1};
    run_phase(5'd2, t, vals);

    // Hex: full table.
    for (i = 0; i < SYMBOL_SLOTS; i++)
      t[i] = (i < 10) ? CHAR_W'(8'h30 + i) : CHAR_W'(8'h41 + (i - 10));
    vals = '{VALUE_MIN, -32'sd1, 32'shDEAD_BEEF, VALUE_MAX};
    run_phase(5'd16, t, vals);

    // Random phases: mostly valid bases, some broken ones.
    good_values = 0;
    while (good_values < RANDOM_VALUES) begin
      quiet = ($urandom_range(0, 3) == 0);
      t     = random_base_symbols();
      case ($urandom_range(0, 6))
        0:       count = 5'd2;
        1:       count = 5'd16;
        default: count = COUNT_W'($urandom_range(2, 16));
      endcase
      for (i = int'(count); i < SYMBOL_SLOTS; i++)
        if ($urandom_range(0, 1)) t[i] = CHAR_W'($urandom_range(0, 255));
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(2, 6);
        case ($urandom_range(0, 3))
          0: count = COUNT_W'($urandom_range(0, 1));
          1: count = COUNT_W'($urandom_range(17, 31));
          2: t[$urandom_range(0, count - 1)] = bad_symbol();
          default: begin
            i    = $urandom_range(1, count - 1);
            j    = $urandom_range(0, i - 1);
            t[i] = t[j];
          end
        endcase
      end else begin
        n = $urandom_range(8, 30);
        good_values += n;
      end
      vals.delete();
      repeat (n) vals.push_back(random_value());
      run_phase(count, t, vals);
    end
    quiet = 1'b0;

    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end
endmodule
